/* rtl/lks_pkg.sv */
// Shared types, constants and helpers for the line keyword search block.
// Used by every module under rtl/; depends on nothing else.
package lks_pkg;

	localparam int MAX_LINE      = 80;
	localparam int KEY_MAX       = 16;
	localparam int LINE_NUM_BITS = 20;

	localparam int COUNT_W = $clog2(MAX_LINE + 1);
	localparam int FILL_W  = $clog2(KEY_MAX + 1);

	localparam int KEY_LEN_W   = 5;
	localparam int KEY_BITS_W  = 128;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 5;
	localparam int LINE_OUT_W  = 20;
	localparam int TEXT_WORDS  = 10;
	localparam int TEXT_BYTES  = 8 * TEXT_WORDS;
	localparam int S_DATA_W    = 16;
	localparam int M_FIELDS_W  = 8 + LINE_OUT_W + 64 * TEXT_WORDS;
	localparam int M_DATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int TEXT_LSB    = 8 + LINE_OUT_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam logic [LINE_NUM_BITS-1:0] LINE_MAX = '1;

	// register indexes (address bits [4:3])
	localparam logic [1:0] REG_KEY_LEN  = 2'd0;
	localparam logic [1:0] REG_KEY_LOW  = 2'd1;
	localparam logic [1:0] REG_KEY_HIGH = 2'd2;

	// beat kinds passed from the front to the back
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_EOI   = 2'd2;

	typedef struct packed {
		logic [7:0] src;
		logic [7:0] data_byte;
		logic [1:0] kind;
	} entry_t;

	typedef struct packed {
		logic [FILL_W-1:0]     klen;
		logic [KEY_BITS_W-1:0] key_bits;
	} key_cfg_t;

	// Effective keyword length: clamp to KEY_MAX, stop before the first zero byte.
	function automatic logic [FILL_W-1:0] key_len(input logic [KEY_LEN_W-1:0] len,
			input logic [KEY_BITS_W-1:0] bits);
		logic [FILL_W-1:0] n;
		logic [FILL_W-1:0] res;
		n = (int'(len) > KEY_MAX) ? FILL_W'(KEY_MAX) : FILL_W'(len);
		res = n;
		for (int i = KEY_MAX - 1; i >= 0; i--) begin
			if ((FILL_W'(i) < n) && (bits[8*i +: 8] == 8'd0)) begin
				res = FILL_W'(i);
			end
		end
		return res;
	endfunction

endpackage

/* rtl/lks_front.sv */
// Front end: accepts input beats, tracks segment length and the zero-byte cut,
// and classifies each byte. Depends on lks_pkg.
module lks_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [lks_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                     s_tlast,
	output logic                     push_valid,
	input  logic                     push_ready,
	output lks_pkg::entry_t          push_data
);

	logic [lks_pkg::COUNT_W-1:0] count_q;
	logic                        zero_q;
	logic                        valid_s1;
	lks_pkg::entry_t             entry_s1;

	logic            accept;
	logic            keep;
	lks_pkg::entry_t entry_d;
	logic [7:0]      src;
	logic [7:0]      data_byte;

	assign src       = s_tdata[7:0];
	assign data_byte = s_tdata[15:8];
	assign s_tready  = !valid_s1 || push_ready;
	assign accept    = s_tvalid && s_tready;

	// Classify the beat; bytes after a zero byte and the zero byte itself are dropped
	always_comb begin
		entry_d.src       = src;
		entry_d.data_byte = data_byte;
		entry_d.kind      = lks_pkg::KIND_DATA;
		keep              = 1'b1;
		if (s_tlast) begin
			entry_d.kind = lks_pkg::KIND_EOI;
		end else if ((count_q >= lks_pkg::COUNT_W'(lks_pkg::MAX_LINE))
				|| (data_byte == lks_pkg::NEWLINE_BYTE)) begin
			entry_d.kind = lks_pkg::KIND_CLOSE;
		end else if (zero_q || (data_byte == 8'd0)) begin
			keep = 1'b0;
		end
	end

	// Advance segment length and zero-byte flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			zero_q  <= 1'b0;
		end else if (accept) begin
			if (entry_d.kind != lks_pkg::KIND_DATA) begin
				count_q <= '0;
				zero_q  <= 1'b0;
			end else begin
				count_q <= count_q + 1'b1;
				if (data_byte == 8'd0) begin
					zero_q <= 1'b1;
				end
			end
		end
	end

	// Hold the classified beat until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= entry_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_data  = entry_s1;

endmodule

/* rtl/lks_queue.sv */
// Short queue of classified beats between front and back.
// Depends on lks_pkg for the entry type and depth.
module lks_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  lks_pkg::entry_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output lks_pkg::entry_t pop_data
);

	lks_pkg::entry_t                  slot_q [lks_pkg::QUEUE_DEPTH];
	logic [lks_pkg::QPTR_W-1:0]       wr_q;
	logic [lks_pkg::QPTR_W-1:0]       rd_q;
	logic [lks_pkg::QCNT_W-1:0]       cnt_q;

	logic do_push;
	logic do_pop;

	assign push_ready = (cnt_q != lks_pkg::QCNT_W'(lks_pkg::QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

/* rtl/lks_back.sv */
// Back end: builds the segment text, runs the keyword window compare, numbers
// lines and holds the result beat for the receiver. Depends on lks_pkg.
module lks_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pop_valid,
	output logic                         pop_ready,
	input  lks_pkg::entry_t              pop_data,
	input  lks_pkg::key_cfg_t            key_cfg,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lks_pkg::M_DATA_W-1:0] m_tdata
);

	localparam int FW = lks_pkg::FILL_W;

	logic [7:0]                        store_q [lks_pkg::MAX_LINE];
	logic [lks_pkg::COUNT_W-1:0]       text_len_q;
	logic [7:0]                        win_q [lks_pkg::KEY_MAX];
	logic [FW-1:0]                     fill_q;
	logic                              found_q;
	logic [lks_pkg::LINE_NUM_BITS-1:0] line_q;

	logic                              out_valid_q;
	logic [7:0]                        out_src_q;
	logic [lks_pkg::LINE_OUT_W-1:0]    out_line_q;
	logic [7:0]                        out_text_q [lks_pkg::TEXT_BYTES];

	logic                              is_data;
	logic                              take;
	logic                              pop_data_beat;
	logic                              pop_close;
	logic                              emit;
	logic                              out_free;
	logic [7:0]                        win_n [lks_pkg::KEY_MAX];
	logic [FW-1:0]                     fill_n;
	logic                              eq;
	logic [FW-1:0]                     kidx;
	logic [lks_pkg::LINE_NUM_BITS-1:0] line_n;

	assign is_data       = (pop_data.kind == lks_pkg::KIND_DATA);
	assign out_free      = !out_valid_q || m_tready;
	assign pop_ready     = is_data || out_free;
	assign take          = pop_valid && pop_ready;
	assign pop_data_beat = take && is_data;
	assign pop_close     = take && !is_data;
	assign emit          = pop_close && (text_len_q != '0)
			&& ((key_cfg.klen == '0) || found_q);
	assign line_n        = (line_q == lks_pkg::LINE_MAX) ? line_q : line_q + 1'b1;

	// Shift the new byte into the window and compare its newest bytes against the keyword
	always_comb begin
		win_n[0] = pop_data.data_byte;
		for (int j = 1; j < lks_pkg::KEY_MAX; j++) begin
			win_n[j] = win_q[j-1];
		end
		fill_n = (fill_q == FW'(lks_pkg::KEY_MAX)) ? fill_q : fill_q + 1'b1;
		eq = (key_cfg.klen != '0) && (fill_n >= key_cfg.klen);
		for (int j = 0; j < lks_pkg::KEY_MAX; j++) begin
			kidx = key_cfg.klen - FW'(1) - FW'(j);
			if ((FW'(j) < key_cfg.klen)
					&& (win_n[j] != key_cfg.key_bits[8*kidx[FW-2:0] +: 8])) begin
				eq = 1'b0;
			end
		end
	end

	// Advance segment state; clear it and advance the line counter when a segment closes (end of input restarts it)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_len_q <= '0;
			fill_q     <= '0;
			found_q    <= 1'b0;
			line_q     <= '0;
		end else if (pop_data_beat) begin
			text_len_q <= text_len_q + 1'b1;
			fill_q     <= fill_n;
			if (eq) begin
				found_q <= 1'b1;
			end
		end else if (pop_close) begin
			text_len_q <= '0;
			fill_q     <= '0;
			found_q    <= 1'b0;
			line_q     <= (pop_data.kind == lks_pkg::KIND_EOI) ? '0 : line_n;
		end
	end

	// Write text bytes and window taps
	always_ff @(posedge clk) begin
		if (pop_data_beat) begin
			for (int i = 0; i < lks_pkg::MAX_LINE; i++) begin
				if (text_len_q == lks_pkg::COUNT_W'(i)) begin
					store_q[i] <= pop_data.data_byte;
				end
			end
			for (int j = 0; j < lks_pkg::KEY_MAX; j++) begin
				win_q[j] <= win_n[j];
			end
		end
	end

	// Hold the result beat until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_src_q  <= pop_data.src;
			out_line_q <= lks_pkg::LINE_OUT_W'(line_n);
			for (int p = 0; p < lks_pkg::TEXT_BYTES; p++) begin
				out_text_q[p] <= 8'd0;
				if (p < lks_pkg::MAX_LINE) begin
					if (lks_pkg::COUNT_W'(p) < text_len_q) begin
						out_text_q[p] <= store_q[p];
					end
				end
			end
		end
	end

	// Pack the result beat
	always_comb begin
		m_tdata        = '0;
		m_tdata[7:0]   = out_src_q;
		m_tdata[lks_pkg::TEXT_LSB-1:8] = out_line_q;
		for (int p = 0; p < lks_pkg::TEXT_BYTES; p++) begin
			m_tdata[lks_pkg::TEXT_LSB + 8*p +: 8] = out_text_q[p];
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

/* rtl/line_keyword_search.sv */
// Top level of the line keyword search block: APB register file plus the
// front, queue and back stages. Depends on lks_pkg, lks_front, lks_queue, lks_back.
//
// Usage: stream a file's bytes on the slave channel, one byte per beat, with
// tlast marking end of input (its byte is ignored). Each nonempty line segment
// (cut at newline, end of input, or a byte arriving while 80 bytes are held)
// that contains the keyword (or any, if the keyword is empty) yields one beat
// on the master channel with the file id, line number and zero-padded text.
// Throughput: one input beat per cycle, sustained, as long as results are
// taken; a closing beat stalls in the back stage only while the single result
// register is still full. A closing beat passes the front register, a queue
// slot and the result register before its result appears.
// Keyword registers are written over APB at byte addresses 0, 8 and 16, by the user
// only while the block is idle (not enforced by the block). The effective keyword
// length is registered in the cycle after. Reset clears segment state, the line
// counter and the registers; no clearing pass is needed. When the receiver stalls,
// the queue of four beats and the front register absorb input before s_tready drops.
module line_keyword_search (
	input  logic                             clk,
	input  logic                             arst_n,
	// s_tdata: source_id [7:0], text_byte [15:8]
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lks_pkg::S_DATA_W-1:0]     s_tdata,
	// s_tlast: end_of_input
	input  logic                             s_tlast,
	// m_tdata: origin_id [7:0], line_number [27:8], text_word_0..9 [667:28], zero pad
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lks_pkg::M_DATA_W-1:0]     m_tdata,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lks_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [lks_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [lks_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready
);

	logic [lks_pkg::KEY_LEN_W-1:0] key_len_q;
	logic [63:0]                   key_low_q;
	logic [63:0]                   key_high_q;
	logic [lks_pkg::FILL_W-1:0]    klen_q;

	logic              wr_en;
	logic [1:0]        reg_idx;
	lks_pkg::key_cfg_t key_cfg;

	logic            push_valid;
	logic            push_ready;
	lks_pkg::entry_t push_data;
	logic            pop_valid;
	logic            pop_ready;
	lks_pkg::entry_t pop_data;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite && pready;

	// Write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q  <= '0;
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				lks_pkg::REG_KEY_LEN:  key_len_q  <= pwdata[lks_pkg::KEY_LEN_W-1:0];
				lks_pkg::REG_KEY_LOW:  key_low_q  <= pwdata;
				lks_pkg::REG_KEY_HIGH: key_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back registers
	always_comb begin
		case (reg_idx)
			lks_pkg::REG_KEY_LEN:  prdata = lks_pkg::CFG_DATA_W'(key_len_q);
			lks_pkg::REG_KEY_LOW:  prdata = key_low_q;
			lks_pkg::REG_KEY_HIGH: prdata = key_high_q;
			default:               prdata = '0;
		endcase
	end

	// Register the effective keyword length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= '0;
		end else begin
			klen_q <= lks_pkg::key_len(key_len_q, {key_high_q, key_low_q});
		end
	end

	assign key_cfg.klen     = klen_q;
	assign key_cfg.key_bits = {key_high_q, key_low_q};

	lks_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	lks_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	lks_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.key_cfg   (key_cfg),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

/* rtl/lks_checker.sv */
// Port-level checks for line_keyword_search, attached by the bind below.
// Depends on lks_pkg for port widths.
module lks_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [lks_pkg::M_DATA_W-1:0]     m_tdata
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// line numbers are one-based
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[lks_pkg::TEXT_LSB-1:8] != '0))
		else $error("result with line number zero");

	// a reported line is nonempty
	a_text_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[lks_pkg::TEXT_LSB +: 8] != 8'd0))
		else $error("result with empty text");

	// padding above the fields stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[lks_pkg::M_DATA_W-1:lks_pkg::M_FIELDS_W] == '0))
		else $error("nonzero padding in result beat");

endmodule

bind line_keyword_search lks_checker u_lks_checker (.*);
